@@ rtl/core/gcpm_pkg.sv @@
// Shared constants and types for the greedy closest point matcher.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gcpm_pkg;

    localparam int MAX_REFS   = 256;
    localparam int COORD_BITS = 16;
    localparam int PORT_W     = 16;
    localparam int IDX_W      = $clog2(MAX_REFS);
    localparam int CNT_W      = $clog2(MAX_REFS + 1);
    localparam int OUT_IDX_W  = 8;
    localparam int DIST_W     = 34;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic [SQ_W-1:0]              t_sq;
    typedef logic [SUM_W-1:0]             t_sum;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic vld;
        logic skip;
        t_idx idx;
    } t_tag;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/gcpm_ref_ram.sv @@
// Reference point memory: one write port, one registered read port.
// Uses the point type and depth from gcpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpm_ref_ram (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  gcpm_pkg::t_idx       i_wr_addr,
    input  gcpm_pkg::t_point     i_wr_data,
    input  wire                  i_rd_en,
    input  gcpm_pkg::t_idx       i_rd_addr,
    output gcpm_pkg::t_point     o_rd_data
);

    gcpm_pkg::t_point r_mem [gcpm_pkg::MAX_REFS];
    gcpm_pkg::t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/gcpm_dist.sv @@
// Three stage squared distance pipeline: difference, square, sum.
// Carries the scan tag alongside the data; uses types from gcpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpm_dist (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gcpm_pkg::t_point     i_query,
    input  gcpm_pkg::t_point     i_ref,
    input  gcpm_pkg::t_tag       i_tag,
    output gcpm_pkg::t_sum       o_dist,
    output gcpm_pkg::t_tag       o_tag,
    output logic                 o_busy
);

    gcpm_pkg::t_diff r_dx, r_dy, r_dz;
    gcpm_pkg::t_sq   r_sx, r_sy, r_sz;
    gcpm_pkg::t_sum  r_sum;
    gcpm_pkg::t_tag  r_tag1, r_tag2, r_tag3;

    logic signed [gcpm_pkg::SQ_W-1:0] px, py, pz;

    always_comb begin
        px = r_dx * r_dx;
        py = r_dy * r_dy;
        pz = r_dz * r_dz;
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= gcpm_pkg::DIFF_W'(i_query.x) - gcpm_pkg::DIFF_W'(i_ref.x);
        r_dy  <= gcpm_pkg::DIFF_W'(i_query.y) - gcpm_pkg::DIFF_W'(i_ref.y);
        r_dz  <= gcpm_pkg::DIFF_W'(i_query.z) - gcpm_pkg::DIFF_W'(i_ref.z);
        r_sx  <= px;
        r_sy  <= py;
        r_sz  <= pz;
        r_sum <= gcpm_pkg::SUM_W'(r_sx) + gcpm_pkg::SUM_W'(r_sy) + gcpm_pkg::SUM_W'(r_sz);
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_dist = r_sum;
    assign o_tag  = r_tag3;
    assign o_busy = r_tag1.vld | r_tag2.vld | r_tag3.vld;

endmodule

`default_nettype wire

@@ rtl/core/greedy_closest_point_match.sv @@
// Greedy closest point matcher. A load item gives no result.
// A match item scans the N loaded references one per cycle through the memory read
// port; after the scan and the distance pipeline drain, the result is registered once
// the output is free, and the next item is accepted in the cycle the result turns valid.
// Reset (synchronous, active low) clears the reference count, all taken marks and the
// output valid; the point memory is not cleared. Depends on gcpm_pkg, gcpm_ref_ram, gcpm_dist.
`timescale 1ns / 1ps
`default_nettype none

module greedy_closest_point_match (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_cmd,
    input  wire                                 i_first,
    input  wire  [gcpm_pkg::PORT_W-1:0]         i_coord_x,
    input  wire  [gcpm_pkg::PORT_W-1:0]         i_coord_y,
    input  wire  [gcpm_pkg::PORT_W-1:0]         i_coord_z,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [gcpm_pkg::OUT_IDX_W-1:0]      o_match_index,
    output logic [gcpm_pkg::DIST_W-1:0]         o_dist_sq,
    output logic                                o_no_match
);

    gcpm_pkg::t_state r_state, n_state;
    logic [gcpm_pkg::CNT_W-1:0]    r_ref_count;
    logic [gcpm_pkg::MAX_REFS-1:0] r_taken;
    gcpm_pkg::t_idx                r_addr;
    gcpm_pkg::t_point              r_query;
    gcpm_pkg::t_tag                r_s1_tag;
    logic                          r_found;
    gcpm_pkg::t_idx                r_best_idx;
    gcpm_pkg::t_sum                r_best_d;

    gcpm_pkg::t_point in_point;
    gcpm_pkg::t_point rd_data;
    gcpm_pkg::t_sum   cur_dist;
    gcpm_pkg::t_tag   dist_tag;
    gcpm_pkg::t_tag   issue_tag;
    gcpm_pkg::t_idx   load_addr;
    logic             dist_busy;
    logic             in_fire;
    logic             load_ok;
    logic             wr_en;
    logic             scan_last;
    logic             out_free;
    logic             upd;

    assign o_in_ready = (r_state == gcpm_pkg::ST_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;

    assign in_point.x = i_coord_x[gcpm_pkg::COORD_BITS-1:0];
    assign in_point.y = i_coord_y[gcpm_pkg::COORD_BITS-1:0];
    assign in_point.z = i_coord_z[gcpm_pkg::COORD_BITS-1:0];

    assign load_addr = i_first ? '0 : r_ref_count[gcpm_pkg::IDX_W-1:0];
    assign load_ok   = i_first | (r_ref_count < gcpm_pkg::CNT_W'(gcpm_pkg::MAX_REFS));
    assign wr_en     = in_fire & ~i_cmd & load_ok;

    assign scan_last = (gcpm_pkg::CNT_W'(r_addr) + gcpm_pkg::CNT_W'(1)) == r_ref_count;
    assign out_free  = ~o_out_valid | i_out_ready;

    assign issue_tag.vld  = (r_state == gcpm_pkg::ST_SCAN);
    assign issue_tag.skip = r_taken[r_addr];
    assign issue_tag.idx  = r_addr;

    assign upd = dist_tag.vld & ~dist_tag.skip & (~r_found | (cur_dist < r_best_d));

    gcpm_ref_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (load_addr),
        .i_wr_data (in_point),
        .i_rd_en   (issue_tag.vld),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    gcpm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (r_query),
        .i_ref   (rd_data),
        .i_tag   (r_s1_tag),
        .o_dist  (cur_dist),
        .o_tag   (dist_tag),
        .o_busy  (dist_busy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcpm_pkg::ST_IDLE: begin
                if (in_fire && i_cmd) begin
                    n_state = (r_ref_count == '0) ? gcpm_pkg::ST_DRAIN : gcpm_pkg::ST_SCAN;
                end
            end
            gcpm_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = gcpm_pkg::ST_DRAIN;
                end
            end
            gcpm_pkg::ST_DRAIN: begin
                if (!r_s1_tag.vld && !dist_busy) begin
                    n_state = gcpm_pkg::ST_DONE;
                end
            end
            gcpm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = gcpm_pkg::ST_IDLE;
                end
            end
            default: n_state = gcpm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_cmd) begin
            r_query <= in_point;
        end
        if (upd) begin
            r_best_idx <= dist_tag.idx;
            r_best_d   <= cur_dist;
        end
        if (r_state == gcpm_pkg::ST_DONE && out_free) begin
            o_match_index <= r_found ? gcpm_pkg::OUT_IDX_W'(r_best_idx) : '0;
            o_dist_sq     <= r_found ? gcpm_pkg::DIST_W'(r_best_d) : '0;
            o_no_match    <= ~r_found;
        end

        if (!i_rst_n) begin
            r_state     <= gcpm_pkg::ST_IDLE;
            r_ref_count <= '0;
            r_taken     <= '0;
            r_addr      <= '0;
            r_s1_tag    <= '0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_tag <= issue_tag;

            if (wr_en) begin
                r_ref_count        <= i_first ? gcpm_pkg::CNT_W'(1)
                                              : r_ref_count + gcpm_pkg::CNT_W'(1);
                r_taken[load_addr] <= 1'b0;
            end

            if (in_fire && i_cmd) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                if (i_first) begin
                    r_taken <= '0;
                end
            end else if (r_state == gcpm_pkg::ST_SCAN && !scan_last) begin
                r_addr <= r_addr + gcpm_pkg::IDX_W'(1);
            end

            if (upd) begin
                r_found <= 1'b1;
            end

            if (r_state == gcpm_pkg::ST_DONE && out_free) begin
                o_out_valid <= 1'b1;
                if (r_found) begin
                    r_taken[r_best_idx] <= 1'b1;
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
